@@ hdl/twt_pkg.sv @@
// Package for the text-mode terminal writer: command codes, character codes,
// the decoded operation type, the back-end states and the queued item type.
// No dependencies.
package twt_pkg;

  localparam logic [1:0] CMD_PUT_CHAR = 2'd0;
  localparam logic [1:0] CMD_CLEAR    = 2'd1;
  localparam logic [1:0] CMD_SET_CUR  = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;
  localparam logic [7:0] TAB_STOP     = 8'd8;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_SET_CUR,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] row;
    logic       in_range;
  } item_t;

endpackage

@@ hdl/twt_front.sv @@
// Front end of the terminal writer: decodes each command word into an
// operation and holds it in a two-entry queue. Depends on twt_pkg.
module twt_front import twt_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_ch,
  input  logic [6:0] in_col,
  input  logic [4:0] in_row,
  input  logic       busy,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t       entry_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push;
  item_t       dec;

  always_comb begin
    dec.ch       = in_ch;
    dec.col      = in_col;
    dec.row      = in_row;
    dec.in_range = ({1'b0, in_col} < 8'(COLUMNS)) && ({1'b0, in_row} < 6'(ROWS));
    dec.op       = OP_PRINT;
    unique case (in_cmd)
      CMD_PUT_CHAR: begin
        priority if (in_ch == CH_NEWLINE) dec.op = OP_NEWLINE;
        else if (in_ch == CH_RETURN)      dec.op = OP_RETURN;
        else if (in_ch == CH_TAB)         dec.op = OP_TAB;
        else if (in_ch == CH_BACKSPACE)   dec.op = OP_BACKSPACE;
        else                              dec.op = OP_PRINT;
      end
      CMD_CLEAR:   dec.op = OP_CLEAR;
      CMD_SET_CUR: dec.op = OP_SET_CUR;
      CMD_READ:    dec.op = OP_READ;
      default:     dec.op = OP_PRINT;
    endcase
  end

  assign full    = (cnt_r == 2'd2) || busy;
  assign do_push = push && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = entry_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? !wptr_r : wptr_r;
    rptr_nxt = q_pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= dec;
    end
  end

endmodule

@@ hdl/twt_back.sv @@
// Back end of the terminal writer: screen memory, cursor, scroll and fill
// sequencer, and the one-entry result register. Depends on twt_pkg.
module twt_back import twt_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  attr,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        init_busy,
  input  logic        res_pop,
  output logic        res_valid,
  output logic [10:0] res_pos,
  output logic [15:0] res_cell,
  output logic        res_ok
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int MOVE  = (ROWS - 1) * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = AW + 1;

  logic [15:0] mem [CELLS];
  logic [15:0] rdata_r;

  state_t         state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [4:0]     row_r, row_nxt;
  logic [6:0]     col_r, col_nxt;
  logic           res_valid_r, res_valid_nxt;
  logic [10:0]    res_pos_r, res_pos_nxt;
  logic [15:0]    res_cell_r, res_cell_nxt;
  logic           res_ok_r, res_ok_nxt;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [15:0]    mem_wdata;
  logic [AW-1:0]  cur_idx;
  logic [7:0]     col_w;
  logic [5:0]     row_w;
  logic           put_op;

  function automatic logic [11:0] lin(input logic [4:0] r, input logic [6:0] c);
    lin = 12'(12'(r) * 12'(COLUMNS)) + 12'(c);
  endfunction

  assign cur_idx   = AW'(lin(row_r, col_r));
  assign init_busy = (state_r == ST_INIT);
  assign res_valid = res_valid_r;
  assign res_pos   = res_pos_r;
  assign res_cell  = res_cell_r;
  assign res_ok    = res_ok_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    res_valid_nxt = res_valid_r && !res_pop;
    res_pos_nxt   = res_pos_r;
    res_cell_nxt  = res_cell_r;
    res_ok_nxt    = res_ok_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_idx;
    mem_wdata     = {attr, BLANK_CHAR};
    mem_raddr     = AW'(lin(q_item.row, q_item.col));
    q_pop         = 1'b0;
    col_w         = {1'b0, col_r};
    row_w         = {1'b0, row_r};
    put_op        = 1'b0;

    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_r);
        mem_wdata = {RESET_ATTR, BLANK_CHAR};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNTW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid && (!res_valid_r || res_pop)) begin
          q_pop        = 1'b1;
          res_cell_nxt = 16'd0;
          res_ok_nxt   = 1'b1;
          unique case (q_item.op)
            OP_PRINT: begin
              put_op    = 1'b1;
              mem_we    = 1'b1;
              mem_wdata = {attr, q_item.ch};
              col_w     = col_w + 8'd1;
            end
            OP_NEWLINE: begin
              put_op = 1'b1;
              col_w  = 8'd0;
              row_w  = row_w + 6'd1;
            end
            OP_RETURN: begin
              put_op = 1'b1;
              col_w  = 8'd0;
            end
            OP_TAB: begin
              put_op = 1'b1;
              col_w  = (col_w + TAB_STOP) & ~(TAB_STOP - 8'd1);
            end
            OP_BACKSPACE: begin
              put_op = 1'b1;
              if (col_r != 7'd0) begin
                col_w     = col_w - 8'd1;
                mem_we    = 1'b1;
                mem_waddr = cur_idx - AW'(1);
              end
            end
            OP_CLEAR: begin
              row_nxt   = 5'd0;
              col_nxt   = 7'd0;
              cnt_nxt   = '0;
              state_nxt = ST_FILL;
            end
            OP_SET_CUR: begin
              res_valid_nxt = 1'b1;
              res_ok_nxt    = q_item.in_range;
              if (q_item.in_range) begin
                row_nxt     = q_item.row;
                col_nxt     = q_item.col;
                res_pos_nxt = 11'(lin(q_item.row, q_item.col));
              end else begin
                res_pos_nxt = 11'(lin(row_r, col_r));
              end
            end
            OP_READ: begin
              if (q_item.in_range) begin
                state_nxt = ST_READ;
              end else begin
                res_valid_nxt = 1'b1;
                res_ok_nxt    = 1'b0;
                res_pos_nxt   = 11'(lin(row_r, col_r));
              end
            end
            default: ;
          endcase

          if (put_op) begin
            if (col_w >= 8'(COLUMNS)) begin
              col_w = 8'd0;
              row_w = row_w + 6'd1;
            end
            if (row_w >= 6'(ROWS)) begin
              // Stepping past the last row: move every line up by one.
              row_w     = 6'(ROWS - 1);
              cnt_nxt   = '0;
              state_nxt = ST_SCROLL;
            end else begin
              res_valid_nxt = 1'b1;
              res_pos_nxt   = 11'(lin(row_w[4:0], col_w[6:0]));
            end
            row_nxt = row_w[4:0];
            col_nxt = col_w[6:0];
          end
        end
      end
      ST_READ: begin
        res_valid_nxt = 1'b1;
        res_cell_nxt  = rdata_r;
        res_ok_nxt    = 1'b1;
        res_pos_nxt   = 11'(lin(row_r, col_r));
        state_nxt     = ST_IDLE;
      end
      ST_SCROLL: begin
        // Read one row ahead; the data read last cycle lands one cell behind.
        mem_raddr = (cnt_r < CNTW'(MOVE)) ? AW'(cnt_r + CNTW'(COLUMNS)) : '0;
        mem_we    = (cnt_r != '0);
        mem_waddr = AW'(cnt_r - 1'b1);
        mem_wdata = rdata_r;
        if (cnt_r == CNTW'(MOVE)) begin
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_r);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNTW'(CELLS - 1)) begin
          res_valid_nxt = 1'b1;
          res_cell_nxt  = 16'd0;
          res_ok_nxt    = 1'b1;
          res_pos_nxt   = 11'(lin(row_r, col_r));
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      row_r       <= 5'd0;
      col_r       <= 7'd0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_pos_r  <= res_pos_nxt;
    res_cell_r <= res_cell_nxt;
    res_ok_r   <= res_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

endmodule

@@ hdl/text_mode_terminal_writer_top.sv @@
// Top level of the text-mode terminal writer: attribute register, front
// decoder queue and back-end engine. Depends on twt_pkg, twt_front, twt_back.
//
//   channel   handshake        payload
//   input     push / full      in_cmd, in_ch, in_col, in_row
//   result    pop / empty      out_cursor_pos, out_cell_data, out_accepted
//   config    cfg_we           cfg_wdata (attribute byte)
//
// A put-char, set-cursor or out-of-range read passes through the queue entry and then
// the result register; an in-range read also passes the registered screen memory read.
// A scroll moves every line up and blanks the last row; a clear blanks every cell.
// After reset the engine blanks every cell of the screen with full held high.
// Two decoded commands queue ahead of the engine while it scrolls or a result waits.
module text_mode_terminal_writer_top import twt_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_ch,
  input  logic [6:0]  in_col,
  input  logic [4:0]  in_row,
  output logic        empty,
  input  logic        pop,
  output logic [10:0] out_cursor_pos,
  output logic [15:0] out_cell_data,
  output logic        out_accepted,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0] attr_r;
  logic       q_valid;
  item_t      q_item;
  logic       q_pop;
  logic       init_busy;
  logic       res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else if (cfg_we) begin
      attr_r <= cfg_wdata;
    end
  end

  twt_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_cmd  (in_cmd),
    .in_ch   (in_ch),
    .in_col  (in_col),
    .in_row  (in_row),
    .busy    (init_busy),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  twt_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      (attr_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .res_pop   (pop),
    .res_valid (res_valid),
    .res_pos   (out_cursor_pos),
    .res_cell  (out_cell_data),
    .res_ok    (out_accepted)
  );

  assign empty = !res_valid;

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("engine took from an empty queue");

  a_pop_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (empty || pop)) else $error("engine took a command with the result slot busy");

  a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> (full && empty)) else $error("word moved during screen blanking");

  a_init_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !q_pop) else $error("command taken during screen blanking");

endmodule
